### sv/salt_pkg.sv
package salt_pkg;

  localparam int ADDR_W  = 58;
  localparam int WHO_W   = 3;
  localparam int STAMP_W = 32;
  localparam int ETAG_W  = 52;
  localparam int AW_W    = 5;
  localparam int WAY_O_W = 4;

  localparam logic CMD_LOOKUP  = 1'b0;
  localparam logic CMD_INSTALL = 1'b1;

  typedef struct packed {
    logic               command;
    logic [ADDR_W-1:0]  line_addr;
    logic               wr_req;
    logic [WHO_W-1:0]   requester;
    logic [STAMP_W-1:0] timestamp;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [WAY_O_W-1:0] way_used;
    logic               evicted_valid;
    logic               evicted_dirty;
    logic [ETAG_W-1:0]  evicted_tag;
    logic [WHO_W-1:0]   evicted_owner;
  } out_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage

### sv/salt_front.sv
module salt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  salt_pkg::in_t  in_data,
  input  salt_pkg::stat_t stat,
  output logic           q_valid,
  output salt_pkg::in_t  q_data,
  input  logic           q_pop
);

  salt_pkg::in_t ent_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;

  assign in_ready = (cnt_r != 2'd2) && !stat.clearing;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= in_data;
    end
  end

endmodule

### sv/salt_back.sv
module salt_back #(
  parameter int SET_CNT = 64,
  parameter int WAY_CNT = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [salt_pkg::AW_W:0]   active_ways,
  input  logic                      q_valid,
  input  salt_pkg::in_t             q_data,
  output logic                      q_pop,
  output salt_pkg::stat_t           stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output salt_pkg::out_t            out_data
);

  localparam int SB   = $clog2(SET_CNT);
  localparam int TAGW = salt_pkg::ADDR_W - SB;
  localparam int OTW  = (TAGW < salt_pkg::ETAG_W) ? TAGW : salt_pkg::ETAG_W;
  localparam int WW   = (WAY_CNT > 1) ? $clog2(WAY_CNT) : 1;
  localparam int LV   = $clog2(WAY_CNT);
  localparam int PW   = 1 << LV;
  localparam int SW   = salt_pkg::STAMP_W;
  localparam int OW   = salt_pkg::WHO_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  // set rows, one entry per way
  logic [WAY_CNT-1:0][TAGW-1:0] tag_mem   [SET_CNT];
  logic [WAY_CNT-1:0][OW-1:0]   own_mem   [SET_CNT];
  logic [WAY_CNT-1:0][SW-1:0]   stamp_mem [SET_CNT];
  logic [WAY_CNT-1:0]           val_mem   [SET_CNT];
  logic [WAY_CNT-1:0]           dty_mem   [SET_CNT];

  logic [WAY_CNT-1:0][TAGW-1:0] rtag_r;
  logic [WAY_CNT-1:0][OW-1:0]   rown_r;
  logic [WAY_CNT-1:0][SW-1:0]   rstamp_r;
  logic [WAY_CNT-1:0]           rval_r;
  logic [WAY_CNT-1:0]           rdty_r;

  logic [WAY_CNT-1:0][TAGW-1:0] wtag;
  logic [WAY_CNT-1:0][OW-1:0]   wown;
  logic [WAY_CNT-1:0][SW-1:0]   wstamp;
  logic [WAY_CNT-1:0]           wval;
  logic [WAY_CNT-1:0]           wdty;

  logic [1:0]          st_r, st_nxt;
  logic [SB-1:0]       clr_r, clr_nxt;
  salt_pkg::in_t       cur_r;
  logic                out_valid_r, out_valid_nxt;
  salt_pkg::out_t      out_r, res;

  logic [SB-1:0]       cur_set;
  logic [TAGW-1:0]     cur_tag;
  logic [5:0]          eff;
  logic [WAY_CNT-1:0]  inuse, hitv, invv;
  logic                any_hit, any_inv;
  logic [WW-1:0]       hit_w, inv_w, vic;
  logic                out_load;

  logic [SW-1:0] nd_stamp [LV+1][PW];
  logic [WW-1:0] nd_idx   [LV+1][PW];
  logic          nd_cand  [LV+1][PW];

  assign cur_set    = cur_r.line_addr[SB-1:0];
  assign cur_tag    = cur_r.line_addr[salt_pkg::ADDR_W-1:SB];
  assign q_pop      = (st_r == ST_IDLE) && q_valid;
  assign out_load   = (st_r == ST_EVAL) && (!out_valid_r || out_ready);
  assign stat.clearing = (st_r == ST_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // zero counts as one, anything past the array counts as all ways
  always_comb begin
    if (active_ways == '0) begin
      eff = 6'd1;
    end else if (active_ways > 6'(WAY_CNT)) begin
      eff = 6'(WAY_CNT);
    end else begin
      eff = active_ways;
    end
  end

  always_comb begin
    any_hit = 1'b0;
    any_inv = 1'b0;
    hit_w   = '0;
    inv_w   = '0;
    for (int w = 0; w < WAY_CNT; w++) begin
      inuse[w] = 6'(w) < eff;
      hitv[w]  = inuse[w] && rval_r[w] && (rtag_r[w] == cur_tag) &&
                 (rown_r[w] == cur_r.requester);
      invv[w]  = inuse[w] && !rval_r[w];
    end
    for (int w = WAY_CNT - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        any_hit = 1'b1;
        hit_w   = WW'(w);
      end
      if (invv[w]) begin
        any_inv = 1'b1;
        inv_w   = WW'(w);
      end
    end
  end

  // victim is the lowest invalid way, else lru search as a pairwise tree, ties keep the lower way
  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int i = 0; i < PW; i++) begin
        nd_stamp[l][i] = '0;
        nd_idx[l][i]   = '0;
        nd_cand[l][i]  = 1'b0;
      end
    end
    for (int i = 0; i < WAY_CNT; i++) begin
      nd_stamp[0][i] = rstamp_r[i];
      nd_idx[0][i]   = WW'(i);
      nd_cand[0][i]  = inuse[i];
    end
    for (int l = 1; l <= LV; l++) begin
      for (int i = 0; i < (PW >> l); i++) begin
        if (nd_cand[l-1][2*i] &&
            (!nd_cand[l-1][2*i+1] || nd_stamp[l-1][2*i] <= nd_stamp[l-1][2*i+1])) begin
          nd_stamp[l][i] = nd_stamp[l-1][2*i];
          nd_idx[l][i]   = nd_idx[l-1][2*i];
          nd_cand[l][i]  = nd_cand[l-1][2*i];
        end else begin
          nd_stamp[l][i] = nd_stamp[l-1][2*i+1];
          nd_idx[l][i]   = nd_idx[l-1][2*i+1];
          nd_cand[l][i]  = nd_cand[l-1][2*i+1];
        end
      end
    end
    vic = any_inv ? inv_w : nd_idx[LV][0];
  end

  always_comb begin
    wtag   = rtag_r;
    wown   = rown_r;
    wstamp = rstamp_r;
    wval   = rval_r;
    wdty   = rdty_r;
    res    = '0;
    if (cur_r.command == salt_pkg::CMD_INSTALL) begin
      res.way_used = salt_pkg::WAY_O_W'(vic);
      if (rval_r[vic]) begin
        res.evicted_valid = 1'b1;
        res.evicted_dirty = rdty_r[vic];
        res.evicted_tag   = salt_pkg::ETAG_W'(rtag_r[vic][OTW-1:0]);
        res.evicted_owner = rown_r[vic];
      end
      wval[vic]   = 1'b1;
      wdty[vic]   = cur_r.wr_req;
      wtag[vic]   = cur_tag;
      wown[vic]   = cur_r.requester;
      wstamp[vic] = cur_r.timestamp;
    end else if (any_hit) begin
      res.hit       = 1'b1;
      res.way_used  = salt_pkg::WAY_O_W'(hit_w);
      wstamp[hit_w] = cur_r.timestamp;
      wdty[hit_w]   = rdty_r[hit_w] | cur_r.wr_req;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SB'(SET_CNT - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          st_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CLEAR) begin
      val_mem[clr_r]   <= '0;
      dty_mem[clr_r]   <= '0;
      stamp_mem[clr_r] <= '0;
    end else if (out_load) begin
      tag_mem[cur_set]   <= wtag;
      own_mem[cur_set]   <= wown;
      stamp_mem[cur_set] <= wstamp;
      val_mem[cur_set]   <= wval;
      dty_mem[cur_set]   <= wdty;
    end
    if (q_pop) begin
      rtag_r   <= tag_mem[q_data.line_addr[SB-1:0]];
      rown_r   <= own_mem[q_data.line_addr[SB-1:0]];
      rstamp_r <= stamp_mem[q_data.line_addr[SB-1:0]];
      rval_r   <= val_mem[q_data.line_addr[SB-1:0]];
      rdty_r   <= dty_mem[q_data.line_addr[SB-1:0]];
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !q_pop) else $error("pop during clear");
  a_load_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && st_r == ST_IDLE)) else $error("load did not complete");
  a_vic_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EVAL) |-> (6'(vic) < eff)) else $error("victim outside active ways");
  a_pop_eval: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == ST_EVAL)) else $error("pop without eval");

endmodule

### sv/set_assoc_cache_lru_tags_unit.sv
// channel  ports                        beat
// in       in_valid/in_ready/in_data    one command (lookup or install)
// out      out_valid/out_ready/out_data one result per command
// cfg      cfg_valid/cfg_ready/cfg_data active_ways write
// the back end handles one item at a time: set row read, then compare and row write
// a 2-entry queue sits between front and back; the result register frees the back end
// after reset a clearing pass runs over all SET_CNT sets, in_ready stays low meanwhile
// out stall holds the back end in its compare step; the queue keeps accepting until full
module set_assoc_cache_lru_tags_unit #(
  parameter int SET_CNT = 64,
  parameter int WAY_CNT = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  salt_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output salt_pkg::out_t            out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [salt_pkg::AW_W-1:0] cfg_data
);

  // one bit wider so that a full 32-way reset value survives
  logic [salt_pkg::AW_W:0]   aw_r;
  logic                      q_valid, q_pop;
  salt_pkg::in_t             q_data;
  salt_pkg::stat_t           stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= (salt_pkg::AW_W + 1)'(WAY_CNT);
    end else if (cfg_valid && cfg_ready) begin
      aw_r <= {1'b0, cfg_data};
    end
  end

  salt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  salt_back #(
    .SET_CNT (SET_CNT),
    .WAY_CNT (WAY_CNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .active_ways (aw_r),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

### tb/sv/tb_set_assoc_cache_lru_tags_unit.sv
`timescale 1ns / 100ps

module tb_set_assoc_cache_lru_tags_unit;

  localparam int NSETS   = 64;
  localparam int NWAYS   = 16;
  localparam int SET_B   = 6;
  localparam int ADDR_B  = salt_pkg::ADDR_W;
  localparam int WHO_B   = salt_pkg::WHO_W;
  localparam int STAMP_B = salt_pkg::STAMP_W;
  localparam int AW_B    = salt_pkg::AW_W;
  localparam int ETAG_B  = salt_pkg::ETAG_W;
  localparam int WAYO_B  = salt_pkg::WAY_O_W;
  localparam int TAG_B   = ADDR_B - SET_B;

  // tag store shadow and expected result queue
  class lru_tag_scoreboard;
    bit              vld[NSETS][NWAYS];
    bit              drt[NSETS][NWAYS];
    bit [TAG_B-1:0]  tg[NSETS][NWAYS];
    bit [WHO_B-1:0]  own[NSETS][NWAYS];
    bit [STAMP_B-1:0] stp[NSETS][NWAYS];
    bit [AW_B-1:0]   ways_reg;
    salt_pkg::out_t  pending[$];
    int              n_bad;
    int              n_ok;
    int              n_hits;
    int              n_evict;

    function void clear_all();
      foreach (vld[s, w]) begin
        vld[s][w] = 1'b0;
        drt[s][w] = 1'b0;
        tg[s][w] = '0;
        own[s][w] = '0;
        stp[s][w] = '0;
      end
      ways_reg = AW_B'(NWAYS);
      n_bad = 0;
      n_ok = 0;
      n_hits = 0;
      n_evict = 0;
    endfunction

    function void note_command(salt_pkg::in_t c);
      salt_pkg::out_t r;
      int set, nw, vic;
      bit [TAG_B-1:0] tag;
      bit found;
      r = '0;
      set = int'(c.line_addr[SET_B-1:0]);
      tag = c.line_addr[ADDR_B-1:SET_B];
      nw = (ways_reg == 0) ? 1 : ((ways_reg > NWAYS) ? NWAYS : int'(ways_reg));
      if (c.command == salt_pkg::CMD_LOOKUP) begin
        for (int w = 0; w < nw; w++) begin
          if (vld[set][w] && tg[set][w] == tag && own[set][w] == c.requester) begin
            if (c.wr_req) drt[set][w] = 1'b1;
            stp[set][w] = c.timestamp;
            r.hit = 1'b1;
            r.way_used = w[WAYO_B-1:0];
            break;
          end
        end
      end else begin
        found = 1'b0;
        vic = 0;
        for (int w = 0; w < nw; w++) begin
          if (!vld[set][w]) begin
            vic = w;
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          for (int w = 1; w < nw; w++)
            if (stp[set][w] < stp[set][vic]) vic = w;
        end
        if (vld[set][vic]) begin
          r.evicted_valid = 1'b1;
          r.evicted_dirty = drt[set][vic];
          r.evicted_tag = tg[set][vic][ETAG_B-1:0];
          r.evicted_owner = own[set][vic];
        end
        vld[set][vic] = 1'b1;
        drt[set][vic] = c.wr_req;
        tg[set][vic] = tag;
        own[set][vic] = c.requester;
        stp[set][vic] = c.timestamp;
        r.way_used = vic[WAYO_B-1:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(salt_pkg::out_t got);
      salt_pkg::out_t exp_r;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch exp hit=%0d way=%0d ev=%0d d=%0d tag=%h own=%0d / got hit=%0d way=%0d ev=%0d d=%0d tag=%h own=%0d",
                   exp_r.hit, exp_r.way_used, exp_r.evicted_valid, exp_r.evicted_dirty,
                   exp_r.evicted_tag, exp_r.evicted_owner, got.hit, got.way_used,
                   got.evicted_valid, got.evicted_dirty, got.evicted_tag, got.evicted_owner);
      end else begin
        n_ok++;
        if (exp_r.hit) n_hits++;
        if (exp_r.evicted_valid) n_evict++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  salt_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  salt_pkg::out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [AW_B-1:0] cfg_data = '0;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  bit stim_done = 0;

  lru_tag_scoreboard sb = new();

  always #10 clk = ~clk;

  set_assoc_cache_lru_tags_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall);
    end
  end

  // recently used line addresses so lookups actually hit
  logic [ADDR_B-1:0] addr_pool[$];
  bit [STAMP_B-1:0] clock_count = 0;

  // valid stays up across back to back beats
  task automatic send_cmd(salt_pkg::in_t c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic write_ways(logic [AW_B-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.ways_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic salt_pkg::in_t make_cmd(bit cmd, logic [ADDR_B-1:0] a);
    salt_pkg::in_t c;
    c.command = cmd;
    c.line_addr = a;
    c.wr_req = 1'($urandom_range(1));
    c.requester = WHO_B'($urandom_range(1));
    c.timestamp = clock_count;
    return c;
  endfunction

  task automatic random_phase(int n, int sidle, int rstall);
    salt_pkg::in_t c;
    logic [ADDR_B-1:0] a;
    send_idle = sidle;
    recv_stall = rstall;
    for (int i = 0; i < n; i++) begin
      clock_count = clock_count + STAMP_B'($urandom_range(40));
      if (addr_pool.size() > 0 && $urandom_range(99) < 55)
        a = addr_pool[$urandom_range(addr_pool.size() - 1)];
      else begin
        // few sets so that ways fill and evict
        a = ADDR_B'({$urandom, $urandom});
        if ($urandom_range(3) != 0) a[ADDR_B-1:SET_B] = TAG_B'($urandom_range(40));
        if ($urandom_range(3) != 0) a[SET_B-1:0] = SET_B'($urandom_range(3));
        addr_pool.push_back(a);
        if (addr_pool.size() > 60) void'(addr_pool.pop_front());
      end
      c = make_cmd($urandom_range(99) < 40, a);
      if ($urandom_range(19) == 0) c.timestamp = $urandom;
      if ($urandom_range(9) == 0) c.requester = WHO_B'($urandom_range(7));
      send_cmd(c);
    end
  endtask

  initial begin
    salt_pkg::in_t c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    sb.clear_all();
    @(posedge clk);
    // directed: extremes, fill and overflow a set, ties, wide tags
    c = make_cmd(salt_pkg::CMD_LOOKUP, '1);
    c.requester = WHO_B'(7); c.wr_req = 1'b1; c.timestamp = '1;
    send_cmd(c);
    c.command = salt_pkg::CMD_INSTALL; send_cmd(c);
    c.command = salt_pkg::CMD_LOOKUP; send_cmd(c);
    c.requester = WHO_B'(3); send_cmd(c);
    c.command = salt_pkg::CMD_INSTALL; send_cmd(c); // same line in a second way
    for (int i = 0; i < 17; i++) begin
      c = make_cmd(salt_pkg::CMD_INSTALL, ADDR_B'(i) << SET_B);
      c.timestamp = (i == 16) ? 32'd0 : 32'd5; // ties then lowest
      c.requester = '0;
      send_cmd(c);
    end
    c = make_cmd(salt_pkg::CMD_LOOKUP, '0); c.requester = '0; send_cmd(c);
    drain();
    write_ways(5'd1);
    random_phase(120, 0, 0);
    drain();
    write_ways(5'd0);
    random_phase(60, 72, 0);
    drain();
    write_ways(5'd31);
    random_phase(150, 0, 72);
    drain();
    write_ways(5'd3);
    random_phase(200, 23, 23);
    drain();
    // fill the queue while the receiver holds off
    hold_cycles = 300;
    write_ways(5'd16);
    random_phase(30, 0, 0);
    random_phase(560, 0, 0);
    in_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d results, %0d lookup hits, %0d evictions, way counts 0..31",
             sb.n_ok, sb.n_hits, sb.n_evict);
    if (sb.n_bad == 0 && sb.pending.size() == 0)
      $display("PASS set_assoc_cache_lru_tags_unit");
    else
      $display("FAIL set_assoc_cache_lru_tags_unit");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL set_assoc_cache_lru_tags_unit");
    $finish;
  end

endmodule
